FILE: hdl/qmf_pkg.sv
// Package with the shared types, constants and coefficient helper of the two-band QMF analysis bank.
package qmf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int ACC_W     = 40;
  localparam int PROTO_LEN = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd58982;

  localparam longint unsigned UNIT_1E12 = 64'd1000000000000;

  localparam longint PROTO_HALF [PROTO_LEN/2] = '{
    64'sd2346222138,    -64'sd3748483183,   -64'sd2060296355,   64'sd8053852109,
    64'sd877952220,     -64'sd14118331865,  64'sd2014489072,    64'sd22662590573,
    -64'sd7923790260,   -64'sd34934726067,  64'sd19393569512,   64'sd54853630449,
    -64'sd44441414673,  -64'sd99381318378,  64'sd132820798102,  64'sd463783133921
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] low_left;
    logic signed [SAMPLE_W-1:0] low_right;
    logic signed [SAMPLE_W-1:0] high_left;
    logic signed [SAMPLE_W-1:0] high_right;
  } out_t;

  // Rounds the prototype tap to cb-1 fraction bits, half away from zero.
  function automatic longint make_coef(int k, int cb);
    longint          p;
    longint unsigned mag;
    longint unsigned q;
    if (k >= PROTO_LEN) begin
      return 0;
    end
    p   = PROTO_HALF[(k < PROTO_LEN/2) ? k : PROTO_LEN-1-k];
    mag = (p < 0) ? longint'(-p) : longint'(p);
    q   = ((mag << (cb-1)) + UNIT_1E12/2) / UNIT_1E12;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

endpackage

FILE: hdl/qmf_analysis_two_band.sv
// Top level of the stereo two-band QMF analysis bank with a memory-held delay line.
//
//   Channel   Signals                        Direction  Contents
//   input     in_valid, in_ready, in_data    in         one stereo sample per transaction
//   output    out_valid, out_ready, out_data out        low and high band, both channels
//   config    cfg_wen, cfg_wdata             in         output gain, 1/65536 units
//
// A sample that produces no output is only written to the history. A sample that produces an output
// starts TAPS reads of the history memory through its single read port, each
// feeding one multiply-accumulate per channel, then four scaling passes through one shared scaling path.
// Reset clears the control state and the per-entry valid bits of the history; no clearing pass.
// A held output delays the next result, and the input stalls for the whole filter pass, also
// while that finished result waits for the output register to free up.
module qmf_analysis_two_band
  import qmf_pkg::*;
#(
  parameter int TAPS      = 32,
  parameter int COEF_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_wen,
  input  logic [GAIN_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(TAPS);
  localparam int PW    = SAMPLE_W + COEF_BITS;
  localparam int VW    = ACC_W + 1;
  localparam int LO_W  = 20;
  localparam int HI_W  = VW - LO_W;
  localparam int GW    = GAIN_W + 1;
  localparam int PPW   = HI_W + GW;
  localparam int PRW   = VW + GW;
  localparam int SH    = COEF_BITS - 1 + 16;
  localparam int HW    = 2 * SAMPLE_W;

  localparam logic [PRW-1:0]      POS_LIMIT = PRW'(32767);
  localparam logic [PRW-1:0]      NEG_LIMIT = PRW'(32768);
  localparam logic [AW-1:0]       LAST_IDX  = AW'(TAPS - 1);

  typedef logic signed [COEF_BITS-1:0] coef_tab_t [TAPS];

  function automatic coef_tab_t build_coefs();
    coef_tab_t t;
    for (int k = 0; k < TAPS; k++) begin
      t[k] = COEF_BITS'(make_coef(k, COEF_BITS));
    end
    return t;
  endfunction

  localparam coef_tab_t COEFS = build_coefs();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC_DRAIN,
    ST_SCALE,
    ST_SC_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    LANE_LL,
    LANE_RL,
    LANE_LH,
    LANE_RH
  } lane_t;

  state_t state;

  logic [HW-1:0]   mem [TAPS];
  logic [HW-1:0]   rd_data;
  logic            rd_vld;
  logic [TAPS-1:0] vld;
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW-1:0]   kc;
  logic [AW-1:0]   k1;
  logic            phase;
  logic [GAIN_W-1:0] gain;

  logic            s1;
  logic            s2;
  logic            par2;
  logic signed [ACC_W-1:0] pl;
  logic signed [ACC_W-1:0] pr;
  logic signed [ACC_W-1:0] acc_al;
  logic signed [ACC_W-1:0] acc_bl;
  logic signed [ACC_W-1:0] acc_ar;
  logic signed [ACC_W-1:0] acc_br;

  lane_t           jc;
  lane_t           j3;
  lane_t           j4;
  lane_t           j5;
  logic            v3;
  logic            v4;
  logic            v5;
  logic signed [VW-1:0]  sc_v;
  logic signed [PPW-1:0] pp_hi;
  logic signed [PPW-1:0] pp_lo;
  logic signed [PRW-1:0] prod;
  out_t            res;

  logic            in_fire;
  logic            wr_en;
  logic [AW-1:0]   wp_next;
  logic [AW-1:0]   rp_next;
  logic signed [SAMPLE_W-1:0]  rd_l;
  logic signed [SAMPLE_W-1:0]  rd_r;
  logic signed [COEF_BITS-1:0] coef_k;
  logic signed [PW-1:0]        mul_l;
  logic signed [PW-1:0]        mul_r;
  logic signed [VW-1:0]        operand;
  logic signed [HI_W-1:0]      v_hi;
  logic signed [LO_W:0]        v_lo;
  logic signed [GW-1:0]        g_s;
  logic [PRW-1:0]              mag5;
  logic [PRW-1:0]              shr5;
  logic signed [SAMPLE_W-1:0]  sat5;
  logic                        emit_ok;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = in_fire;
  assign wp_next  = (wp == LAST_IDX) ? '0 : wp + AW'(1);
  assign rp_next  = (rp == LAST_IDX) ? '0 : rp + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= {in_data.right_sample, in_data.left_sample};
    end
    rd_data <= mem[rp];
  end

  assign rd_l   = rd_vld ? $signed(rd_data[SAMPLE_W-1:0]) : '0;
  assign rd_r   = rd_vld ? $signed(rd_data[HW-1:SAMPLE_W]) : '0;
  assign coef_k = COEFS[k1];
  assign mul_l  = rd_l * coef_k;
  assign mul_r  = rd_r * coef_k;

  always_comb begin
    case (jc)
      LANE_LL: operand = VW'(acc_al) + VW'(acc_bl);
      LANE_RL: operand = VW'(acc_ar) + VW'(acc_br);
      LANE_LH: operand = VW'(acc_al) - VW'(acc_bl);
      LANE_RH: operand = VW'(acc_ar) - VW'(acc_br);
      default: operand = '0;
    endcase
  end

  assign v_hi = sc_v[VW-1:LO_W];
  assign v_lo = $signed({1'b0, sc_v[LO_W-1:0]});
  assign g_s  = $signed({1'b0, gain});

  always_comb begin
    mag5 = prod[PRW-1] ? PRW'(-prod) : PRW'(prod);
    shr5 = mag5 >> SH;
    if (!prod[PRW-1]) begin
      sat5 = (shr5 > POS_LIMIT) ? 16'sh7fff : $signed(shr5[SAMPLE_W-1:0]);
    end else begin
      sat5 = (shr5 > NEG_LIMIT) ? 16'sh8000 : $signed(SAMPLE_W'(-shr5));
    end
  end

  assign emit_ok = !v3 && !v4 && !v5 && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    pl    <= ACC_W'(mul_l);
    pr    <= ACC_W'(mul_r);
    par2  <= k1[0];
    sc_v  <= operand;
    j3    <= jc;
    pp_hi <= PPW'(v_hi * g_s);
    pp_lo <= PPW'(v_lo * g_s);
    j4    <= j3;
    prod  <= (PRW'(pp_hi) <<< LO_W) + PRW'(pp_lo);
    j5    <= j4;
    if (v5) begin
      case (j5)
        LANE_LL: res.low_left   <= sat5;
        LANE_RL: res.low_right  <= sat5;
        LANE_LH: res.high_left  <= sat5;
        LANE_RH: res.high_right <= sat5;
        default: res.low_left   <= sat5;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      wp        <= '0;
      rp        <= '0;
      kc        <= '0;
      k1        <= '0;
      phase     <= 1'b0;
      gain      <= GAIN_RESET;
      rd_vld    <= 1'b0;
      s1        <= 1'b0;
      s2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      jc        <= LANE_LL;
      acc_al    <= '0;
      acc_bl    <= '0;
      acc_ar    <= '0;
      acc_br    <= '0;
      out_valid <= 1'b0;
      out_data  <= '0;
    end else begin
      if (cfg_wen) begin
        gain <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= vld[rp];
      s1     <= 1'b0;
      s2     <= s1;
      v3     <= 1'b0;
      v4     <= v3;
      v5     <= v4;
      if (s2) begin
        if (par2) begin
          acc_bl <= acc_bl + pl;
          acc_br <= acc_br + pr;
        end else begin
          acc_al <= acc_al + pl;
          acc_ar <= acc_ar + pr;
        end
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            vld[wp] <= 1'b1;
            wp      <= wp_next;
            phase   <= ~phase;
            if (!phase) begin
              rp     <= wp_next;
              kc     <= '0;
              acc_al <= '0;
              acc_bl <= '0;
              acc_ar <= '0;
              acc_br <= '0;
              state  <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          s1 <= 1'b1;
          k1 <= kc;
          rp <= rp_next;
          kc <= kc + AW'(1);
          if (kc == LAST_IDX) begin
            state <= ST_ACC_DRAIN;
          end
        end
        ST_ACC_DRAIN: begin
          if (!s1 && !s2) begin
            jc    <= LANE_LL;
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          v3 <= 1'b1;
          jc <= lane_t'(jc + 2'd1);
          if (jc == LANE_RH) begin
            state <= ST_SC_DRAIN;
          end
        end
        ST_SC_DRAIN: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_even_odd_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase) |=> (state == ST_IDLE))
    else $error("A sample on the odd phase started a filter pass.");

  a_acc_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE) |-> (!s1 && !s2))
    else $error("Scaling started before the accumulators settled.");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    s2 |-> $past(s1))
    else $error("Accumulate stage fired without a preceding multiply.");

  a_emit_after_scale: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_SC_DRAIN) && !v3 && !v4 && !v5)
    else $error("Output transaction issued before scaling finished.");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the stereo two-band QMF analysis bank under random flow control.
`timescale 1ns / 100ps

module testbench
  import qmf_pkg::*;
();

  localparam int TAPS       = 32;
  localparam int COEF_BITS  = 16;
  localparam int SETTLE     = TAPS + 30;
  localparam int STUCK_MAX  = 5000;
  localparam int PRESS_AT   = 80;
  localparam int PRESS_LEN  = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_wen = 1'b0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  in_t               sample_q[$];
  out_t              band_q[$];
  logic [31:0]       sample_line[TAPS];
  bit                odd_phase;
  logic [GAIN_W-1:0] gain_now;
  longint            coef_tab[TAPS];
  int                fail_count;
  int                queued_total;
  int                results_seen;
  int                send_gap;
  int                hold_cycles;
  int                stuck_cycles;
  bit                send_calm;
  bit                take_calm;

  int dir_l[22] = '{0, 32767, -32768, 32767, -32768, -1, 1, 21845, -21846, 0, 16384,
                    -16384, 32767, 32767, -32768, -32768, 255, -256, 0, 1, 32767, 0};
  int dir_r[22] = '{0, -32768, 32767, 32767, -32768, 1, -1, -21846, 21845, 0, -16384,
                    16384, -32768, -32768, 32767, 32767, -256, 255, 0, -1, 0, 32767};

  qmf_analysis_two_band #(
    .TAPS(TAPS),
    .COEF_BITS(COEF_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint tap_weight(int k);
    longint p;
    longint mag;
    longint unit;
    if (k >= PROTO_LEN) begin
      return 0;
    end
    unit = 64'd1000000000000;
    p    = (k < PROTO_LEN / 2) ? PROTO_HALF[k] : PROTO_HALF[PROTO_LEN - 1 - k];
    mag  = (p < 0) ? -p : p;
    mag  = (mag * (64'd1 << (COEF_BITS - 1)) + unit / 2) / unit;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [15:0] scale_clip(longint v);
    longint p;
    longint q;
    p = v * longint'(gain_now);
    if (p < 0) begin
      q = -((-p) >> (COEF_BITS - 1 + 16));
    end else begin
      q = p >> (COEF_BITS - 1 + 16);
    end
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return 16'(q);
  endfunction

  task automatic predict_bands(input in_t s);
    logic signed [39:0] even_l;
    logic signed [39:0] odd_l;
    logic signed [39:0] even_r;
    logic signed [39:0] odd_r;
    longint             xl;
    longint             xr;
    out_t               want;
    for (int k = 0; k + 1 < TAPS; k++) begin
      sample_line[k] = sample_line[k + 1];
    end
    sample_line[TAPS - 1] = {s.right_sample, s.left_sample};
    odd_phase = ~odd_phase;
    if (odd_phase) begin
      even_l = '0;
      odd_l  = '0;
      even_r = '0;
      odd_r  = '0;
      for (int k = 0; k < TAPS; k++) begin
        xl = longint'($signed(sample_line[k][15:0]));
        xr = longint'($signed(sample_line[k][31:16]));
        if (k % 2 == 1) begin
          odd_l = odd_l + 40'(xl * coef_tab[k]);
          odd_r = odd_r + 40'(xr * coef_tab[k]);
        end else begin
          even_l = even_l + 40'(xl * coef_tab[k]);
          even_r = even_r + 40'(xr * coef_tab[k]);
        end
      end
      want.low_left   = scale_clip(longint'(even_l) + longint'(odd_l));
      want.low_right  = scale_clip(longint'(even_r) + longint'(odd_r));
      want.high_left  = scale_clip(longint'(even_l) - longint'(odd_l));
      want.high_right = scale_clip(longint'(even_r) - longint'(odd_r));
      band_q = {band_q, want};
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_bands(input out_t got);
    out_t want;
    if (band_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = band_q.pop_front();
    if (got.low_left !== want.low_left) begin
      report_mismatch($sformatf("low_left %0d, expected %0d", got.low_left, want.low_left));
    end
    if (got.low_right !== want.low_right) begin
      report_mismatch($sformatf("low_right %0d, expected %0d", got.low_right, want.low_right));
    end
    if (got.high_left !== want.high_left) begin
      report_mismatch($sformatf("high_left %0d, expected %0d", got.high_left, want.high_left));
    end
    if (got.high_right !== want.high_right) begin
      report_mismatch($sformatf("high_right %0d, expected %0d", got.high_right,
                                want.high_right));
    end
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(30, 120);
  endfunction

  task automatic push_sample(input int l, input int r);
    in_t s;
    s.left_sample  = 16'(l);
    s.right_sample = 16'(r);
    sample_q = {sample_q, s};
    queued_total++;
  endtask

  // Full-scale samples whose signs follow the taps, so that a window aligned with the
  // decimation drives one band of the channel into saturation.
  function automatic int aligned_value(int idx, bit high_band, bit flip);
    bit neg;
    neg = (coef_tab[idx] < 0) ^ (high_band && idx % 2 == 1) ^ flip;
    if (!neg) begin
      return $urandom_range(30000, 32767);
    end
    if ($urandom_range(0, 3) == 0) begin
      return -32768;
    end
    return -int'($urandom_range(30000, 32767));
  endfunction

  task automatic push_aligned(input int n);
    bit hi_l;
    bit hi_r;
    bit flip_l;
    bit flip_r;
    int idx;
    hi_l   = $urandom_range(0, 1);
    hi_r   = $urandom_range(0, 1);
    flip_l = $urandom_range(0, 1);
    flip_r = $urandom_range(0, 1);
    repeat (n) begin
      idx = (queued_total + 1) % TAPS;
      push_sample(aligned_value(idx, hi_l, flip_l), aligned_value(idx, hi_r, flip_r));
    end
  endtask

  task automatic push_random(input int n);
    int mode;
    int seg;
    int lvl_l;
    int lvl_r;
    while (n > 0) begin
      mode = $urandom_range(0, 9);
      seg  = (mode < 3) ? $urandom_range(64, 96) : $urandom_range(4, 40);
      if (seg > n) begin
        seg = n;
      end
      lvl_l = $urandom_range(0, 1) ? 32767 : -32768;
      lvl_r = $urandom_range(0, 1) ? 32767 : -32768;
      if (mode < 3) begin
        push_aligned(seg);
      end else begin
        repeat (seg) begin
          case (mode)
            3, 4, 5: begin
              push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            6, 7: begin
              push_sample(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8);
            end
            8: begin
              push_sample(lvl_l, lvl_r);
            end
            default: begin
              push_sample(lvl_l, lvl_r);
              lvl_l = (lvl_l > 0) ? -32768 : 32767;
              lvl_r = (lvl_r > 0) ? -32768 : 32767;
            end
          endcase
        end
      end
      n -= seg;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || band_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    gain_now  = g;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bands(in_data);
      end
      if ($urandom_range(0, 199) == 0) begin
        send_calm = ~send_calm;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The long hold at PRESS_AT results lets the input side fill the block and stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_bands(out_data);
        results_seen++;
        if (results_seen == PRESS_AT) begin
          hold_cycles = PRESS_LEN;
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        take_calm = ~take_calm;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_cycles = pick_gap(take_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < TAPS; k++) begin
      coef_tab[k]    = tap_weight(k);
      sample_line[k] = '0;
    end
    odd_phase = 1'b0;
    gain_now  = GAIN_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 22; i++) begin
      push_sample(dir_l[i], dir_r[i]);
    end
    wait_idle();

    write_gain(16'hFFFF);
    push_aligned(96);
    push_random(204);
    wait_idle();

    write_gain(16'h0000);
    push_random(60);
    wait_idle();

    write_gain(16'h0001);
    push_aligned(64);
    wait_idle();

    write_gain(16'h8000);
    push_random(250);
    wait_idle();

    write_gain(16'($urandom_range(0, 65535)));
    push_random(220);
    wait_idle();

    write_gain(GAIN_RESET);
    push_random(130);
    wait_idle();

    if (band_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", band_q.size()));
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
